[sv/assert_macros.svh]
// Assertion macros shared by the RTL of the fixed-point square root block.
// No dependencies; defining NO_ASSERTIONS turns every macro into nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled while reset is held.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled while reset is held.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

[sv/csqrt_pkg.sv]
// Shared widths, constants and stage payload types of the square root pipeline.
// No dependencies.
package csqrt_pkg;

    localparam int RAD_W     = 31;
    localparam int ROOT_W    = 22;
    localparam int DATA_W    = 30;
    localparam int H_W       = 5;
    localparam int ROT_COUNT = 7;

    localparam logic [ROOT_W-1:0]       ROOT_MAX    = {ROOT_W{1'b1}};
    localparam logic [DATA_W-1:0]       SEED_OFFSET = 30'h05D50AD;
    localparam logic [DATA_W-1:0]       SEED_SPAN   = SEED_OFFSET << 1;
    localparam logic signed [H_W-1:0]   H_MIN       = -5'sd11;
    localparam logic signed [H_W-1:0]   H_MAX       = 5'sd3;
    localparam logic signed [H_W-1:0]   SCALE_BASE  = 5'sd6;

    // Shift of each hyperbolic vectoring rotation; the fourth shift is repeated.
    function automatic int rot_shift(input int k);
        int s;
        case (k)
            0:       s = 1;
            1:       s = 2;
            2:       s = 3;
            3:       s = 4;
            4:       s = 4;
            5:       s = 5;
            default: s = 6;
        endcase
        return s;
    endfunction

    // Payload after the leading-zero stage.
    typedef struct packed {
        logic                  zero;
        logic signed [H_W-1:0] h;
        logic [RAD_W-1:0]      r;
    } t_norm_data;

    // Payload carried through the rotation cells.
    typedef struct packed {
        logic                     zero;
        logic signed [H_W-1:0]    h;
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
    } t_rot_data;

endpackage

[sv/cordic_fixed_sqrt_top.sv]
// Top level of the 19.12 fixed-point square root: front stages, rotation chain, output.
// Depends on csqrt_pkg, csqrt_norm, csqrt_seed, csqrt_cell, csqrt_scale, assert_macros.svh.
//
//   channel   direction  handshake                  payload
//   input     in         i_in_valid / o_in_ready    i_radicand [30:0]
//   output    out        o_out_valid / i_out_ready  o_root [21:0]
//
// A new transaction is accepted every cycle unless the output holds the chain; the path
// runs through the leading-zero stage, seed stage, seven rotation cells and output register.
// Each stage holds one transaction and moves on when the next stage is empty or
// moving, so bubbles close up while the output waits.
// Reset clears every stage valid bit; payload registers are not reset.
`include "assert_macros.svh"
module cordic_fixed_sqrt_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [csqrt_pkg::RAD_W-1:0]  i_radicand,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [csqrt_pkg::ROOT_W-1:0] o_root
);
    import csqrt_pkg::*;

    logic       w_norm_valid;
    t_norm_data w_norm_data;
    logic       w_seed_ready;

    logic       w_rot_valid [ROT_COUNT+1];
    t_rot_data  w_rot_data  [ROT_COUNT+1];
    logic       w_rot_ready [ROT_COUNT+1];

    // Leading-zero count and half exponent.
    csqrt_norm u_norm (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_up_valid    (i_in_valid),
        .i_up_radicand (i_radicand),
        .o_up_ready    (o_in_ready),
        .o_dn_valid    (w_norm_valid),
        .o_dn_data     (w_norm_data),
        .i_dn_ready    (w_seed_ready)
    );

    // Normalizing shift and CORDIC seed.
    csqrt_seed u_seed (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_up_valid (w_norm_valid),
        .i_up_data  (w_norm_data),
        .o_up_ready (w_seed_ready),
        .o_dn_valid (w_rot_valid[0]),
        .o_dn_data  (w_rot_data[0]),
        .i_dn_ready (w_rot_ready[0])
    );

    // Chain of rotation cells.
    for (genvar k = 0; k < ROT_COUNT; k++) begin : g_cell
        csqrt_cell #(
            .P_SHIFT (rot_shift(k))
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_up_valid (w_rot_valid[k]),
            .i_up_data  (w_rot_data[k]),
            .o_up_ready (w_rot_ready[k]),
            .o_dn_valid (w_rot_valid[k+1]),
            .o_dn_data  (w_rot_data[k+1]),
            .i_dn_ready (w_rot_ready[k+1])
        );
    end

    // Rescale, clamp and output register.
    csqrt_scale u_scale (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_up_valid (w_rot_valid[ROT_COUNT]),
        .i_up_data  (w_rot_data[ROT_COUNT]),
        .o_up_ready (w_rot_ready[ROT_COUNT]),
        .o_dn_valid (o_out_valid),
        .o_dn_root  (o_root),
        .i_dn_ready (i_out_ready)
    );

    // A drained output lets the whole chain move, so the front must accept.
    `ASSERT_IMPL(a_front_ready, i_clk, i_rst_n, !o_out_valid || i_out_ready, o_in_ready, "front stalled with output free")
    // Half exponent of a nonzero radicand stays within -11 to 3.
    `ASSERT_IMPL(a_h_range, i_clk, i_rst_n, w_norm_valid && !w_norm_data.zero, (w_norm_data.h >= H_MIN) && (w_norm_data.h <= H_MAX), "half exponent out of range")
    // Seeded x and y differ by twice the seed offset.
    `ASSERT_IMPL(a_seed_span, i_clk, i_rst_n, w_rot_valid[0], DATA_W'(w_rot_data[0].x - w_rot_data[0].y) == SEED_SPAN, "bad CORDIC seed")
    // A zero radicand leaving the chain comes out as a zero root.
    `ASSERT_NEXT(a_zero_root, i_clk, i_rst_n, w_rot_valid[ROT_COUNT] && w_rot_data[ROT_COUNT].zero && w_rot_ready[ROT_COUNT], o_out_valid && (o_root == '0), "zero radicand gave nonzero root")

endmodule

[sv/csqrt_norm.sv]
// Front stage: leading-zero count of the radicand and the half exponent h.
// Depends on csqrt_pkg.
module csqrt_norm (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_up_valid,
    input  logic [csqrt_pkg::RAD_W-1:0] i_up_radicand,
    output logic                    o_up_ready,
    output logic                    o_dn_valid,
    output csqrt_pkg::t_norm_data   o_dn_data,
    input  logic                    i_dn_ready
);
    import csqrt_pkg::*;

    // Leading zeros of one nibble, 0 to 4.
    function automatic logic [2:0] nib_lz(input logic [3:0] n);
        logic [2:0] z;
        unique case (n)
            4'b0000:                            z = 3'd4;
            4'b0001:                            z = 3'd3;
            4'b0010, 4'b0011:                   z = 3'd2;
            4'b0100, 4'b0101, 4'b0110, 4'b0111: z = 3'd1;
            default:                            z = 3'd0;
        endcase
        return z;
    endfunction

    // Leading zeros of a 32-bit word: per-nibble counts, then the first nonzero nibble.
    function automatic logic [5:0] lzc32(input logic [31:0] w);
        logic [5:0] n;
        logic       found;
        n     = 6'd32;
        found = 1'b0;
        for (int i = 7; i >= 0; i--) begin
            if (!found && (w[4*i +: 4] != 4'b0000)) begin
                n     = 6'(4 * (7 - i)) + 6'(nib_lz(w[4*i +: 4]));
                found = 1'b1;
            end
        end
        return n;
    endfunction

    logic              r_valid;
    t_norm_data        r_data;
    t_norm_data        n_data;
    logic [5:0]        w_lz;
    logic signed [6:0] w_b;
    logic signed [6:0] w_h;

    // b = 8 - L; h is floor(b/2), plus one when b is negative.
    always_comb begin
        w_lz = lzc32({1'b0, i_up_radicand});
        w_b  = 7'sd8 - $signed({1'b0, w_lz});
        w_h  = (w_b >>> 1) + $signed({6'd0, w_b[6]});
        n_data.zero = (i_up_radicand == '0);
        n_data.h    = w_h[H_W-1:0];
        n_data.r    = i_up_radicand;
    end

    assign o_up_ready = !r_valid || i_dn_ready;

    // Stage valid bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_up_ready) begin
            r_valid <= i_up_valid;
        end
    end

    // Stage payload.
    always_ff @(posedge i_clk) begin
        if (o_up_ready && i_up_valid) begin
            r_data <= n_data;
        end
    end

    assign o_dn_valid = r_valid;
    assign o_dn_data  = r_data;

endmodule

[sv/csqrt_seed.sv]
// Seed stage: even normalizing shift of the radicand and the CORDIC start values.
// Depends on csqrt_pkg.
module csqrt_seed (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_up_valid,
    input  csqrt_pkg::t_norm_data i_up_data,
    output logic                  o_up_ready,
    output logic                  o_dn_valid,
    output csqrt_pkg::t_rot_data  o_dn_data,
    input  logic                  i_dn_ready
);
    import csqrt_pkg::*;

    // The normalized operand always stays below 2^25.
    localparam int V_W = 25;

    logic              r_valid;
    t_rot_data         r_data;
    t_rot_data         n_data;
    logic [H_W-1:0]    w_neg_h;
    logic [H_W:0]      w_sh_l;
    logic [H_W:0]      w_sh_r;
    logic [V_W-1:0]    w_v;

    // Shift right by 2h for h >= 0, left by -2h otherwise, then seed x and y.
    always_comb begin
        w_neg_h = H_W'(-i_up_data.h);
        w_sh_l  = {w_neg_h, 1'b0};
        w_sh_r  = {i_up_data.h, 1'b0};
        if (i_up_data.h[H_W-1]) begin
            w_v = i_up_data.r[V_W-1:0] << w_sh_l;
        end else begin
            w_v = V_W'(i_up_data.r >> w_sh_r);
        end
        n_data.zero = i_up_data.zero;
        n_data.h    = i_up_data.h;
        n_data.x    = $signed(DATA_W'(w_v) + SEED_OFFSET);
        n_data.y    = $signed(DATA_W'(w_v) - SEED_OFFSET);
    end

    assign o_up_ready = !r_valid || i_dn_ready;

    // Stage valid bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_up_ready) begin
            r_valid <= i_up_valid;
        end
    end

    // Stage payload.
    always_ff @(posedge i_clk) begin
        if (o_up_ready && i_up_valid) begin
            r_data <= n_data;
        end
    end

    assign o_dn_valid = r_valid;
    assign o_dn_data  = r_data;

endmodule

[sv/csqrt_cell.sv]
// One hyperbolic vectoring rotation cell of the CORDIC chain, one register stage.
// Depends on csqrt_pkg.
module csqrt_cell #(
    parameter int P_SHIFT = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_up_valid,
    input  csqrt_pkg::t_rot_data i_up_data,
    output logic                 o_up_ready,
    output logic                 o_dn_valid,
    output csqrt_pkg::t_rot_data o_dn_data,
    input  logic                 i_dn_ready
);
    import csqrt_pkg::*;

    logic      r_valid;
    t_rot_data r_data;
    t_rot_data n_data;

    // Drive y toward zero; both updates use the incoming x and y.
    always_comb begin
        n_data.zero = i_up_data.zero;
        n_data.h    = i_up_data.h;
        if (!i_up_data.y[DATA_W-1]) begin
            n_data.x = i_up_data.x - (i_up_data.y >>> P_SHIFT);
            n_data.y = i_up_data.y - (i_up_data.x >>> P_SHIFT);
        end else begin
            n_data.x = i_up_data.x + (i_up_data.y >>> P_SHIFT);
            n_data.y = i_up_data.y + (i_up_data.x >>> P_SHIFT);
        end
    end

    assign o_up_ready = !r_valid || i_dn_ready;

    // Cell valid bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_up_ready) begin
            r_valid <= i_up_valid;
        end
    end

    // Cell payload.
    always_ff @(posedge i_clk) begin
        if (o_up_ready && i_up_valid) begin
            r_data <= n_data;
        end
    end

    assign o_dn_valid = r_valid;
    assign o_dn_data  = r_data;

endmodule

[sv/csqrt_scale.sv]
// Output stage: rescales x by 6 - h, clamps to the root range and holds the result.
// Depends on csqrt_pkg.
module csqrt_scale (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_up_valid,
    input  csqrt_pkg::t_rot_data        i_up_data,
    output logic                        o_up_ready,
    output logic                        o_dn_valid,
    output logic [csqrt_pkg::ROOT_W-1:0] o_dn_root,
    input  logic                        i_dn_ready
);
    import csqrt_pkg::*;

    logic                     r_valid;
    logic [ROOT_W-1:0]        r_root;
    logic [ROOT_W-1:0]        n_root;
    logic signed [H_W-1:0]    w_amt;
    logic signed [DATA_W-1:0] w_res;

    // Arithmetic shift right by 6 - h (3 to 17), then clamp; a zero radicand gives zero.
    always_comb begin
        w_amt = SCALE_BASE - i_up_data.h;
        w_res = i_up_data.x >>> $unsigned(w_amt);
        if (i_up_data.zero || w_res[DATA_W-1]) begin
            n_root = '0;
        end else if (w_res > $signed(DATA_W'(ROOT_MAX))) begin
            n_root = ROOT_MAX;
        end else begin
            n_root = w_res[ROOT_W-1:0];
        end
    end

    assign o_up_ready = !r_valid || i_dn_ready;

    // Output valid bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_up_ready) begin
            r_valid <= i_up_valid;
        end
    end

    // Output result register.
    always_ff @(posedge i_clk) begin
        if (o_up_ready && i_up_valid) begin
            r_root <= n_root;
        end
    end

    assign o_dn_valid = r_valid;
    assign o_dn_root  = r_root;

endmodule
